FILE: rtl/core/sls_pkg.sv
// Package for the sorted list store: words, command and status codes, cell controls.
`default_nettype none
package sls_pkg;

  // Number of cells in the chain
  localparam int unsigned CAPACITY = 16;
  // Width of the held-entry counter, able to hold CAPACITY itself
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W = 32;
  localparam int unsigned COUNT_OUT_W = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_POP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Per-cycle action broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_POP    = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [VAL_W-1:0]   value;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]              command;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                status;
    logic                      found;
    logic signed [VAL_W-1:0]   popped_value;
    logic [COUNT_OUT_W-1:0]    entry_count;
  } out_word_t;

endpackage
`default_nettype wire

FILE: rtl/core/sls_cell.sv
// One cell of the sorted chain: holds an entry, compares it and shifts with its neighbors.
`default_nettype none
module sls_cell (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire sls_pkg::cell_ctl_t             ctl,
  input  wire logic                           prev_lt,
  input  wire logic signed [sls_pkg::VAL_W-1:0] left_val,
  input  wire logic                           left_vld,
  input  wire logic signed [sls_pkg::VAL_W-1:0] right_val,
  input  wire logic                           right_vld,
  output logic signed [sls_pkg::VAL_W-1:0]    val_o,
  output logic                                vld_o,
  output logic                                lt_o,
  output logic                                head_o
);

  logic signed [sls_pkg::VAL_W-1:0] val_r, val_nxt;
  logic                             vld_r, vld_nxt;
  logic                             lt;

  // Compare against the broadcast value
  assign lt     = vld_r & (val_r < ctl.value);
  // First entry not below the value, and equal to it
  assign head_o = vld_r & (val_r == ctl.value) & prev_lt;
  assign lt_o   = lt;
  assign val_o  = val_r;
  assign vld_o  = vld_r;

  // Next entry: keep, take the new value, or shift up/down one place
  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    unique case (ctl.op)
      sls_pkg::CELL_HOLD: begin
      end
      sls_pkg::CELL_INSERT: begin
        if (!lt) begin
          if (prev_lt) begin
            val_nxt = ctl.value;
            vld_nxt = 1'b1;
          end else begin
            val_nxt = left_val;
            vld_nxt = left_vld;
          end
        end
      end
      sls_pkg::CELL_REMOVE: begin
        if (!lt) begin
          val_nxt = right_val;
          vld_nxt = right_vld;
        end
      end
      sls_pkg::CELL_POP: begin
        val_nxt = right_val;
        vld_nxt = right_vld;
      end
      default: begin
      end
    endcase
  end

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Entry value, no reset needed
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/core/sorted_list_store_top.sv
// Top level of the sorted list store: command decode, cell chain, counter and result register.
//
//   channel | ports                          | word
//   --------+--------------------------------+------------------------------
//   input   | in_valid, in_ready, in_data    | command, value
//   result  | out_valid, out_ready, out_data | status, found, popped_value,
//           |                                | entry_count
//
// One word per cycle: every cell compares and shifts in the cycle the word is
// accepted, and the result appears in the output register on the next cycle.
// The path per cycle is the 32-bit compares in each cell plus an OR over the cells.
// Reset (rst_n low, synchronous) empties the chain; entry values are not cleared.
// While a result waits unread, a new word is taken only in the cycle it is read.
`default_nettype none
module sorted_list_store_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sls_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sls_pkg::out_word_t      out_data
);

  localparam int unsigned N = sls_pkg::CAPACITY;

  logic signed [sls_pkg::VAL_W-1:0] cell_val [N];
  logic [N-1:0]                     cell_vld;
  logic [N-1:0]                     cell_lt;
  logic [N-1:0]                     cell_head;

  sls_pkg::cell_ctl_t ctl;
  logic [sls_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                      out_valid_r, out_valid_nxt;
  sls_pkg::out_word_t        out_data_r, out_data_nxt;
  logic                      accept;
  logic                      full;
  logic                      empty;
  logic                      found_any;
  sls_pkg::cmd_t             cmd;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cmd       = sls_pkg::cmd_t'(in_data.command);
  assign full      = (count_r == sls_pkg::CNT_W'(N));
  assign empty     = (count_r == '0);
  assign found_any = |cell_head;

  // Cell chain
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                             prev_lt_w;
    logic signed [sls_pkg::VAL_W-1:0] left_val_w;
    logic                             left_vld_w;
    logic signed [sls_pkg::VAL_W-1:0] right_val_w;
    logic                             right_vld_w;

    if (i == 0) begin : g_first
      assign prev_lt_w  = 1'b1;
      assign left_val_w = '0;
      assign left_vld_w = 1'b0;
    end else begin : g_mid
      assign prev_lt_w  = cell_lt[i-1];
      assign left_val_w = cell_val[i-1];
      assign left_vld_w = cell_vld[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_val_w = '0;
      assign right_vld_w = 1'b0;
    end else begin : g_inner
      assign right_val_w = cell_val[i+1];
      assign right_vld_w = cell_vld[i+1];
    end

    sls_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .prev_lt   (prev_lt_w),
      .left_val  (left_val_w),
      .left_vld  (left_vld_w),
      .right_val (right_val_w),
      .right_vld (right_vld_w),
      .val_o     (cell_val[i]),
      .vld_o     (cell_vld[i]),
      .lt_o      (cell_lt[i]),
      .head_o    (cell_head[i])
    );
  end

  // Decode: cell action, count update and result word
  always_comb begin
    ctl.op                    = sls_pkg::CELL_HOLD;
    ctl.value                 = in_data.value;
    count_nxt                 = count_r;
    out_data_nxt.status       = sls_pkg::ST_DONE;
    out_data_nxt.found        = 1'b0;
    out_data_nxt.popped_value = '0;
    unique case (cmd)
      sls_pkg::CMD_INSERT: begin
        if (full) begin
          out_data_nxt.status = sls_pkg::ST_FULL;
        end else begin
          ctl.op    = sls_pkg::CELL_INSERT;
          count_nxt = count_r + 1'b1;
        end
      end
      sls_pkg::CMD_SEARCH: begin
        out_data_nxt.found = found_any;
        if (!found_any) begin
          out_data_nxt.status = sls_pkg::ST_NOT_FOUND;
        end
      end
      sls_pkg::CMD_DELETE: begin
        out_data_nxt.found = found_any;
        if (found_any) begin
          ctl.op    = sls_pkg::CELL_REMOVE;
          count_nxt = count_r - 1'b1;
        end else begin
          out_data_nxt.status = sls_pkg::ST_NOT_FOUND;
        end
      end
      sls_pkg::CMD_POP: begin
        if (empty) begin
          out_data_nxt.status = sls_pkg::ST_EMPTY;
        end else begin
          ctl.op                    = sls_pkg::CELL_POP;
          out_data_nxt.popped_value = cell_val[0];
          count_nxt                 = count_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
    out_data_nxt.entry_count = sls_pkg::COUNT_OUT_W'(count_nxt);
    if (!accept) begin
      ctl.op    = sls_pkg::CELL_HOLD;
      count_nxt = count_r;
    end
  end

  // Output valid follows accept and read
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Count never exceeds the chain length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sls_pkg::CNT_W'(N))
    else $error("entry count above capacity");

  // Valid cells agree with the counter
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_vld) == 32'(count_r))
    else $error("valid cells disagree with entry count");

  // A search leaves the store size alone
  a_search_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (cmd == sls_pkg::CMD_SEARCH) |=> count_r == $past(count_r))
    else $error("search changed entry count");

  // A pop from a non-empty store removes exactly one entry
  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (cmd == sls_pkg::CMD_POP) && !empty |=>
      count_r == $past(count_r) - 1'b1)
    else $error("pop did not remove one entry");

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Testbench for the sorted list store: directed, back-pressure and random words against a shadow list.
module testbench;

  typedef logic signed [sls_pkg::VAL_W-1:0] val_t;

  localparam val_t VAL_MIN = {1'b1, {(sls_pkg::VAL_W-1){1'b0}}};
  localparam val_t VAL_MAX = {1'b0, {(sls_pkg::VAL_W-1){1'b1}}};
  localparam int unsigned IDLE_PCT       = 18;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned HOLD_OFF       = 200;
  localparam int unsigned RAND_BLOCKS    = 16;
  localparam int unsigned BLOCK_WORDS    = 50;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  sls_pkg::in_word_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  sls_pkg::out_word_t out_data;

  // Shadow copy of the sorted store and results still owed by the block
  val_t               shadow_list[$];
  sls_pkg::out_word_t pending_results[$];

  int error_count     = 0;
  int words_sent      = 0;
  int results_checked = 0;
  int full_drops      = 0;
  int empty_pops      = 0;
  int match_hits      = 0;
  int hold_left       = 0;
  bit in_gaps_on      = 1'b1;
  bit out_stalls_on   = 1'b1;

  sorted_list_store_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one word to the shadow list and returns the result the block owes for it
  function automatic sls_pkg::out_word_t apply_to_shadow(input sls_pkg::in_word_t w);
    sls_pkg::out_word_t r;
    int pos;
    r = '0;
    r.status = sls_pkg::ST_DONE;
    pos = 0;
    case (sls_pkg::cmd_t'(w.command))
      sls_pkg::CMD_INSERT: begin
        if (shadow_list.size() >= sls_pkg::CAPACITY) begin
          r.status = sls_pkg::ST_FULL;
        end else begin
          // lands in front of the first entry not smaller, so a new value goes ahead of equal ones
          while (pos < shadow_list.size() && shadow_list[pos] < w.value) pos++;
          shadow_list.insert(pos, w.value);
        end
      end
      sls_pkg::CMD_SEARCH, sls_pkg::CMD_DELETE: begin
        while (pos < shadow_list.size() && shadow_list[pos] != w.value) pos++;
        if (pos < shadow_list.size()) begin
          r.found = 1'b1;
          if (sls_pkg::cmd_t'(w.command) == sls_pkg::CMD_DELETE) shadow_list.delete(pos);
        end else begin
          r.status = sls_pkg::ST_NOT_FOUND;
        end
      end
      sls_pkg::CMD_POP: begin
        if (shadow_list.size() == 0) r.status = sls_pkg::ST_EMPTY;
        else r.popped_value = shadow_list.pop_front();
      end
      default: ;
    endcase
    r.entry_count = sls_pkg::COUNT_OUT_W'(shadow_list.size());
    return r;
  endfunction

  // Operand mix: small values for duplicates, held values for hits, corners, and noise
  function automatic val_t pick_value();
    int unsigned k;
    val_t corner[4];
    corner = '{VAL_MIN, VAL_MIN + 1, VAL_MAX - 1, VAL_MAX};
    k = $urandom_range(99);
    if (k < 30 || (k < 55 && shadow_list.size() == 0)) begin
      return val_t'(int'($urandom_range(16)) - 8);
    end
    if (k < 55) return shadow_list[$urandom_range(shadow_list.size() - 1)];
    if (k < 65) return corner[$urandom_range(3)];
    return val_t'($urandom);
  endfunction

  // Offers one word, holds it until taken, then books the expected result
  task automatic send_word(input sls_pkg::cmd_t cmd, input val_t operand);
    sls_pkg::out_word_t r;
    while (in_gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, value: operand};
    do @(posedge clk); while (!in_ready);
    r = apply_to_shadow(in_data);
    pending_results.push_back(r);
    words_sent++;
    if (r.status == sls_pkg::ST_FULL) full_drops++;
    if (r.status == sls_pkg::ST_EMPTY) empty_pops++;
    if (r.found) match_hits++;
  endtask

  // Sender goes quiet until the block has returned everything owed
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Empty store, extremes, duplicates, hits and misses, pops down to empty
  task automatic test_directed();
    send_word(sls_pkg::CMD_POP, 0);
    send_word(sls_pkg::CMD_SEARCH, VAL_MAX);
    send_word(sls_pkg::CMD_DELETE, VAL_MIN);
    send_word(sls_pkg::CMD_INSERT, VAL_MAX);
    send_word(sls_pkg::CMD_INSERT, VAL_MIN);
    send_word(sls_pkg::CMD_INSERT, 0);
    send_word(sls_pkg::CMD_INSERT, -1);
    send_word(sls_pkg::CMD_INSERT, 0);
    send_word(sls_pkg::CMD_INSERT, VAL_MIN);
    send_word(sls_pkg::CMD_SEARCH, VAL_MIN);
    send_word(sls_pkg::CMD_SEARCH, 1);
    send_word(sls_pkg::CMD_DELETE, 0);
    send_word(sls_pkg::CMD_SEARCH, 0);
    send_word(sls_pkg::CMD_DELETE, 12345);
    // pop ignores its operand
    send_word(sls_pkg::CMD_POP, VAL_MAX);
    repeat (5) send_word(sls_pkg::CMD_POP, -1);
  endtask

  // Receiver holds off, which stalls the inserts; they then run past capacity and pops drain it
  task automatic test_backpressure();
    int i;
    hold_left = HOLD_OFF;
    for (i = 0; i < sls_pkg::CAPACITY + 4; i++) send_word(sls_pkg::CMD_INSERT, pick_value());
    wait_for_results();
    for (i = 0; i <= sls_pkg::CAPACITY; i++) send_word(sls_pkg::CMD_POP, val_t'($urandom));
  endtask

  // Blocks of random words; insert share swings so the store runs full and empty
  task automatic test_random();
    int blk;
    int n;
    int unsigned bias;
    int unsigned bias_pct[5];
    sls_pkg::cmd_t others[3];
    sls_pkg::cmd_t cmd;
    bias_pct = '{70, 25, 85, 50, 10};
    others   = '{sls_pkg::CMD_SEARCH, sls_pkg::CMD_DELETE, sls_pkg::CMD_POP};
    for (blk = 0; blk < RAND_BLOCKS; blk++) begin
      // one block runs flat out on both sides
      in_gaps_on    = (blk != 6);
      out_stalls_on = (blk != 6);
      bias = bias_pct[blk % 5];
      for (n = 0; n < BLOCK_WORDS; n++) begin
        if ($urandom_range(99) < bias) cmd = sls_pkg::CMD_INSERT;
        else cmd = others[$urandom_range(2)];
        send_word(cmd, pick_value());
      end
    end
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  // Result side: compare against the oldest expectation, then pick next ready
  always @(posedge clk) begin : result_check
    sls_pkg::out_word_t exp_word;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: status %0d, count %0d",
               out_data.status, out_data.entry_count);
        error_count++;
      end else begin
        exp_word = pending_results.pop_front();
        results_checked++;
        if (out_data.status !== exp_word.status) begin
          $error("status: expected %0d, got %0d", exp_word.status, out_data.status);
          error_count++;
        end
        if (out_data.found !== exp_word.found) begin
          $error("found: expected %0d, got %0d", exp_word.found, out_data.found);
          error_count++;
        end
        if (out_data.popped_value !== exp_word.popped_value) begin
          $error("popped_value: expected %0d, got %0d",
                 exp_word.popped_value, out_data.popped_value);
          error_count++;
        end
        if (out_data.entry_count !== exp_word.entry_count) begin
          $error("entry_count: expected %0d, got %0d",
                 exp_word.entry_count, out_data.entry_count);
          error_count++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(out_stalls_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  // Watchdog: too long without any handshake ends the run
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    do begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end while (quiet_cycles < WATCHDOG_LIMIT);
    $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("testbench: done, errors");
    $finish;
  end

  // Sequence: reset, then each test in turn
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_for_results();
    test_backpressure();
    test_random();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("testbench: %0d words sent, %0d results compared field by field",
             words_sent, results_checked);
    $display("testbench: %0d inserts dropped when full, %0d pops on empty, %0d matches",
             full_drops, empty_pops, match_hits);
    if (error_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sls_pkg.sv
rtl/core/sls_cell.sv
rtl/core/sorted_list_store_top.sv
bench/testbench.sv
